[sv/base64_line_wrap_encoder_assert.svh]
// Assertion macros for the checker file.
`ifndef BASE64_LINE_WRAP_ENCODER_ASSERT_SVH
`define BASE64_LINE_WRAP_ENCODER_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted.
`define BLWE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: %m");

// Clocked assertion that also holds during reset.
`define BLWE_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed: %m");

`endif

[sv/blwe_pkg.sv]
package blwe_pkg;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    localparam logic [7:0] GPL_RESET = 8'd18;
    localparam int         QUEUE_DEPTH_DEF = 2;

    localparam int         PADDR_W  = 3;
    localparam logic [PADDR_W-1:0] ADDR_GPL = 3'd0;

    // Character slots of one transaction run: four symbols, then CR, LF.
    localparam logic [2:0] SLOT_SYM_LAST = 3'd3;
    localparam logic [2:0] SLOT_CR       = 3'd4;
    localparam logic [2:0] SLOT_LF       = 3'd5;

    // One encoded group waiting to be sent.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic            brk;
    } blwe_job_t;

    // Standard base64 alphabet.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
            c = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            c = 8'h61 + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            c = 8'h30 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            c = 8'h2B;
        else
            c = 8'h2F;
        return c;
    endfunction

endpackage

[sv/blwe_in_if.sv]
interface blwe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
    modport mon    (input valid, input data_byte, input final_byte, input ready);
endinterface

[sv/blwe_out_if.sv]
interface blwe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
    modport mon    (input valid, input out_char, input last_of_run, input ready);
endinterface

[sv/blwe_front.sv]
module blwe_front
    import blwe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] groups_per_line,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    input  logic       q_full,
    output logic       push,
    output blwe_job_t  push_job
);

    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;
    logic [1:0] fill_reg, fill_next;
    logic [7:0] line_reg, line_next;

    logic       accept;
    logic [7:0] limit;
    logic [8:0] line_inc;
    logic [7:0] b0, b1, b2;
    logic [1:0] count;
    logic [5:0] s0, s1, s2, s3;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign limit    = (groups_per_line == 8'd0) ? 8'd1 : groups_per_line;
    assign line_inc = {1'b0, line_reg} + 9'd1;

    always_comb
    begin
        held0_next = held0_reg;
        held1_next = held1_reg;
        fill_next  = fill_reg;
        line_next  = line_reg;
        push       = 1'b0;
        b0         = held0_reg;
        b1         = held1_reg;
        b2         = data_byte;
        count      = 2'd3;
        push_job.brk = 1'b0;

        if (accept)
        begin
            priority if (fill_reg == 2'd2)
            begin
                push         = 1'b1;
                push_job.brk = final_byte || (line_inc >= {1'b0, limit});
                line_next    = push_job.brk ? 8'd0 : line_inc[7:0];
                fill_next    = 2'd0;
            end
            else if (final_byte)
            begin
                // flush a partial group, always closed by a line break
                push         = 1'b1;
                push_job.brk = 1'b1;
                line_next    = 8'd0;
                fill_next    = 2'd0;
                b2           = 8'd0;
                if (fill_reg == 2'd0)
                begin
                    b0    = data_byte;
                    b1    = 8'd0;
                    count = 2'd1;
                end
                else
                begin
                    b1    = data_byte;
                    count = 2'd2;
                end
            end
            else
            begin
                if (fill_reg == 2'd0)
                    held0_next = data_byte;
                else
                    held1_next = data_byte;
                fill_next = fill_reg + 2'd1;
            end
        end

        s0 = b0[7:2];
        s1 = {b0[1:0], b1[7:4]};
        s2 = {b1[3:0], b2[7:6]};
        s3 = b2[5:0];
        push_job.chars[0] = b64_char(s0);
        push_job.chars[1] = b64_char(s1);
        push_job.chars[2] = (count > 2'd1) ? b64_char(s2) : CHAR_PAD;
        push_job.chars[3] = (count > 2'd2) ? b64_char(s3) : CHAR_PAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held0_reg <= 8'd0;
            held1_reg <= 8'd0;
            fill_reg  <= 2'd0;
            line_reg  <= 8'd0;
        end
        else
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            fill_reg  <= fill_next;
            line_reg  <= line_next;
        end
    end

endmodule

[sv/blwe_queue.sv]
module blwe_queue
    import blwe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  blwe_job_t push_job,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output blwe_job_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    blwe_job_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

[sv/blwe_back.sv]
module blwe_back
    import blwe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  blwe_job_t  job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last_of_run
);

    logic [2:0] slot_reg, slot_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;

    logic       load;
    logic [2:0] slot_end;
    logic [7:0] cur_char;

    assign load     = !valid_reg || out_ready;
    assign slot_end = job.brk ? SLOT_LF : SLOT_SYM_LAST;

    always_comb
    begin
        if (slot_reg == SLOT_CR)
            cur_char = CHAR_CR;
        else if (slot_reg == SLOT_LF)
            cur_char = CHAR_LF;
        else
            cur_char = job.chars[slot_reg[1:0]];
    end

    always_comb
    begin
        slot_next  = slot_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = job_valid;
            if (job_valid)
            begin
                char_next = cur_char;
                last_next = (slot_reg == slot_end);
                pop       = (slot_reg == slot_end);
                slot_next = pop ? 3'd0 : slot_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid   = valid_reg;
    assign out_char    = char_reg;
    assign last_of_run = last_reg;

endmodule

[sv/base64_line_wrap_encoder.sv]
// base64_line_wrap_encoder - MIME base64 encoder with CR LF line wrapping.
// Input channel in_ch: one raw byte per transaction, final_byte marks the
// last byte of a message. Output channel out_ch: one ASCII character per
// transaction, last_of_run high on the last character caused by an input byte.
// Bytes that only gather into an open group produce no output at all.
// The first character of a group is written into the queue and then into
// the output register before it appears.
// Throughput: one character per cycle from the output sequencer while the
// receiver is ready and a group is queued; a group of up to three bytes is
// four characters, or six with CR LF. The front takes a byte every cycle
// while the job queue has room.
// Register groups_per_line (APB, byte address 0): groups before each CR LF,
// reset 18; zero behaves as one. Write it only while the encoder is idle.
// Reset: the open group, line count and queue are emptied, out_ch.valid drops.
// Receiver stall: the output register holds its character, the queue fills,
// and then in_ch.ready drops until space frees up.
module base64_line_wrap_encoder
    import blwe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    blwe_in_if.sink            in_ch,
    blwe_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0] gpl_reg;
    logic       cfg_wr;

    logic       q_push, q_full, q_pop, q_not_empty;
    blwe_job_t  q_push_job, q_head;

    // Configuration port: zero wait states, write on the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_GPL);
    assign prdata = (paddr == ADDR_GPL) ? {24'd0, gpl_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gpl_reg <= GPL_RESET;
        else if (cfg_wr)
            gpl_reg <= pwdata[7:0];
    end

    // Front: gather bytes, encode a finished or flushed group, decide on the line break.
    blwe_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .groups_per_line (gpl_reg),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .data_byte       (in_ch.data_byte),
        .final_byte      (in_ch.final_byte),
        .q_full          (q_full),
        .push            (q_push),
        .push_job        (q_push_job)
    );

    // Hold encoded groups so that a stalled receiver does not stop the front at once.
    blwe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Back: walk the characters of the head group, one per output transaction.
    blwe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_not_empty),
        .job         (q_head),
        .pop         (q_pop),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_char    (out_ch.out_char),
        .last_of_run (out_ch.last_of_run)
    );

endmodule

[sv/blwe_checker.sv]
`include "base64_line_wrap_encoder_assert.svh"

module blwe_checker
    import blwe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    blwe_out_if.source out_ch
);

    logic out_acc;
    assign out_acc = out_ch.valid && out_ch.ready;

    // A stalled character holds until taken.
    `BLWE_ASSERT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.out_char) && $stable(out_ch.last_of_run))

    // CR is always followed by LF within the same run.
    `BLWE_ASSERT(a_cr_not_last, clk, rst_n, out_acc && out_ch.out_char == CHAR_CR |-> !out_ch.last_of_run)

    // LF only ever closes a run.
    `BLWE_ASSERT(a_lf_last, clk, rst_n, out_acc && out_ch.out_char == CHAR_LF |-> out_ch.last_of_run)

    // Padding only comes with a flush, which always ends in CR LF.
    `BLWE_ASSERT(a_pad_not_last, clk, rst_n, out_acc && out_ch.out_char == CHAR_PAD |-> !out_ch.last_of_run)

endmodule

bind base64_line_wrap_encoder blwe_checker u_blwe_checker (.*);
